/* design/sorted_key_table_macros.svh */
// Assertion macros used by the sorted key table datapath.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SKT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted key table check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted key table check failed");

`endif

/* design/skt_pkg.sv */
// Package with types, constants and codes of the sorted key table.
package skt_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int FUNC_W    = 1;
	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 32;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 4;
	localparam int COUNT_W   = 5;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_MISS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_SRCH_CHK,
		ST_SRCH_CMP,
		ST_RESP
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FULL,
		OP_INS_READ,
		OP_INS_SHIFT,
		OP_INS_PLACE,
		OP_SRCH_READ,
		OP_SRCH_UP,
		OP_SRCH_DOWN,
		OP_FOUND,
		OP_MISS
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;
		logic   in_ready;
	} cmd_t;

	typedef struct packed {
		logic is_search;
		logic full;
		logic slot_zero;
		logic range_empty;
		logic key_lt_rd;
		logic key_eq_rd;
		logic out_busy;
	} sts_t;

endpackage

/* design/skt_ifs.sv */
// Request and response channel interfaces of the sorted key table.
interface skt_req_if import skt_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [FUNC_W-1:0]           func;
	logic signed [KEY_W-1:0]     key;
	logic [PAYLOAD_W-1:0]        payload;

	modport source(output valid, func, key, payload, input ready);
	modport sink(input valid, func, key, payload, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [POS_W-1:0]      position;
	logic [COUNT_W-1:0]    entry_count;

	modport source(output valid, status, position, entry_count, input ready);
	modport sink(input valid, status, position, entry_count, output ready);
endinterface

/* design/skt_ram.sv */
// Generic single write port RAM with one registered read port.
module skt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/skt_ctrl.sv */
// Controller state machine that sequences inserts and searches.
module skt_ctrl import skt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.emit     = 1'b0;
		cmd.in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_search) begin
					state_d = ST_SRCH_CHK;
				end else if (sts.full) begin
					cmd.op  = OP_FULL;
					state_d = ST_RESP;
				end else begin
					state_d = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				if (sts.slot_zero) begin
					cmd.op  = OP_INS_PLACE;
					state_d = ST_RESP;
				end else begin
					cmd.op  = OP_INS_READ;
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (sts.key_lt_rd) begin
					cmd.op  = OP_INS_SHIFT;
					state_d = ST_INS_CHK;
				end else begin
					cmd.op  = OP_INS_PLACE;
					state_d = ST_RESP;
				end
			end
			ST_SRCH_CHK: begin
				if (sts.range_empty) begin
					cmd.op  = OP_MISS;
					state_d = ST_RESP;
				end else begin
					cmd.op  = OP_SRCH_READ;
					state_d = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (sts.key_eq_rd) begin
					cmd.op  = OP_FOUND;
					state_d = ST_RESP;
				end else if (sts.key_lt_rd) begin
					cmd.op  = OP_SRCH_DOWN;
					state_d = ST_SRCH_CHK;
				end else begin
					cmd.op  = OP_SRCH_UP;
					state_d = ST_SRCH_CHK;
				end
			end
			ST_RESP: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/skt_dp.sv */
// Datapath with the entry memory, the search bounds and the result register.
`include "sorted_key_table_macros.svh"

module skt_dp import skt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [FUNC_W-1:0]       req_func,
	input  logic signed [KEY_W-1:0] req_key,
	input  logic [PAYLOAD_W-1:0]    req_payload,
	input  logic                    rsp_ready,
	output logic                    rsp_valid,
	output logic [STATUS_W-1:0]     rsp_status,
	output logic [POS_W-1:0]        rsp_position,
	output logic [COUNT_W-1:0]      rsp_entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = KEY_W + PAYLOAD_W;

	logic [FUNC_W-1:0]       func_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAYLOAD_W-1:0]    payload_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           slot_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;
	status_t                 res_status_q;
	logic [CW-1:0]           res_pos_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [COUNT_W-1:0]      out_count_q;

	logic [CW:0]             mid_sum;
	logic [CW-1:0]           mid;
	logic [CW-1:0]           slot_m1;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;
	logic [EW-1:0]           wdata;
	logic [EW-1:0]           rdata;
	logic signed [KEY_W-1:0] rd_key;
	logic [CW+POS_W-1:0]     pos_ext;
	logic [CW+COUNT_W-1:0]   count_ext;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
	assign mid     = mid_sum[CW:1];
	assign slot_m1 = slot_q - {{(CW-1){1'b0}}, 1'b1};
	assign rd_key  = $signed(rdata[EW-1:PAYLOAD_W]);

	assign we    = (cmd.op == OP_INS_SHIFT) || (cmd.op == OP_INS_PLACE);
	assign waddr = slot_q[AW-1:0];
	assign wdata = (cmd.op == OP_INS_SHIFT) ? rdata : {key_q, payload_q};
	assign raddr = (cmd.op == OP_INS_READ) ? slot_m1[AW-1:0] : mid[AW-1:0];

	skt_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.is_search   = (func_q == FUNC_SEARCH);
		sts.full        = (count_q == CW'(DEPTH));
		sts.slot_zero   = (slot_q == '0);
		sts.range_empty = (lo_q == hi_q);
		sts.key_lt_rd   = (key_q < rd_key);
		sts.key_eq_rd   = (key_q == rd_key);
		sts.out_busy    = out_valid_q && !rsp_ready;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q    <= req_func;
				key_q     <= req_key;
				payload_q <= req_payload;
				slot_q    <= count_q;
				lo_q      <= '0;
				hi_q      <= count_q;
			end
			OP_INS_SHIFT: begin
				slot_q <= slot_m1;
			end
			OP_INS_PLACE: begin
				res_status_q <= STATUS_OK;
				res_pos_q    <= slot_q;
			end
			OP_FULL, OP_MISS: begin
				res_status_q <= (cmd.op == OP_FULL) ? STATUS_FULL : STATUS_MISS;
				res_pos_q    <= '0;
			end
			OP_FOUND: begin
				res_status_q <= STATUS_OK;
				res_pos_q    <= mid;
			end
			OP_SRCH_UP: begin
				lo_q <= mid + {{(CW-1){1'b0}}, 1'b1};
			end
			OP_SRCH_DOWN: begin
				hi_q <= mid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_INS_PLACE) begin
			count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
		end
	end

	assign pos_ext   = {{POS_W{1'b0}}, res_pos_q};
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_pos_q    <= pos_ext[POS_W-1:0];
			out_count_q  <= count_ext[COUNT_W-1:0];
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_status      = out_status_q;
	assign rsp_position    = out_pos_q;
	assign rsp_entry_count = out_count_q;

	`SKT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`SKT_ASSERT_NEXT(a_place_counts, cmd.op == OP_INS_PLACE, count_q == CW'($past(count_q) + 1'b1))
	`SKT_ASSERT_NOW(a_no_place_full, cmd.op == OP_INS_PLACE, count_q != CW'(DEPTH))
	`SKT_ASSERT_NOW(a_probe_in_range, cmd.op == OP_SRCH_READ, (lo_q < hi_q) && (hi_q <= count_q))
	`SKT_ASSERT_NOW(a_emit_free, cmd.emit, !(out_valid_q && !rsp_ready))

endmodule

/* design/sorted_key_table.sv */
// Sorted key table top level: up to DEPTH entries ordered by signed key.
// An insert shifts larger entries up one slot at a time before it places the new entry,
// and it answers with a full status when the table is full.
// A search probes the entries by binary search and answers with a hit or a miss.
// The next item is taken in the cycle after a result is issued, so one item is handled at a time.
// Reset clears count, control and the response valid flag; memory and result data are kept.
module sorted_key_table import skt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	assign req.ready = cmd.in_ready;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	skt_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_func       (req.func),
		.req_key        (req.key),
		.req_payload    (req.payload),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_status     (rsp.status),
		.rsp_position   (rsp.position),
		.rsp_entry_count(rsp.entry_count)
	);

endmodule
